FILE: rtl/core/csl_pkg.sv
package csl_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  localparam logic [62:0] VALUE_MAX = {63{1'b1}};

  typedef enum logic [2:0] {
    KIND_NUM     = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_PUNCT   = 3'd2,
    KIND_KEYWORD = 3'd3,
    KIND_END     = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  // keyword slots: bit 0 return, bit 1 if, bit 2 else
  localparam int unsigned KW_COUNT = 3;
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd2, 3'd4};

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start_offset;
    logic [15:0] length;
    logic [62:0] number_value;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] r;
    r = 8'd0;
    case (k)
      2'd0: begin
        case (i)
          3'd0: r = "r";
          3'd1: r = "e";
          3'd2: r = "t";
          3'd3: r = "u";
          3'd4: r = "r";
          3'd5: r = "n";
          default: r = 8'd0;
        endcase
      end
      2'd1: begin
        case (i)
          3'd0: r = "i";
          3'd1: r = "f";
          default: r = 8'd0;
        endcase
      end
      2'd2: begin
        case (i)
          3'd0: r = "e";
          3'd1: r = "l";
          3'd2: r = "s";
          3'd3: r = "e";
          default: r = 8'd0;
        endcase
      end
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/csl_step.sv
module csl_step #(
  parameter int unsigned OFFSET_BITS = csl_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  csl_pkg::in_word_t in_word_i,
  output csl_pkg::push_t   push_o
);
  import csl_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_PUNCT,
    MODE_ERROR
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] len_q, len_d;
  logic [62:0]            acc_q, acc_d;
  logic [7:0]             punct_q, punct_d;
  logic [2:0]             cand_q, cand_d;

  logic [7:0]             c;
  logic                   eot;
  logic                   is_space, is_digit, is_alpha, is_punct, pend_pair;
  logic [3:0]             digit;
  logic [66:0]            acc_x10, acc_sum;
  logic [62:0]            acc_next;
  logic [OFFSET_BITS-1:0] pos_inc, len_inc;
  logic [31:0]            pos_ext, start_ext, len_ext;
  logic [2:0]             narrow_cont, narrow_first;
  logic                   is_kw;
  logic                   flush_v;
  out_word_t              flush_w, pair_w, end_w, err_w;
  logic                   a_v, b_v;
  out_word_t              a_w, b_w;
  logic [1:0]             n;
  out_word_t              res0, res1;

  assign c   = in_word_i.ch;
  assign eot = in_word_i.end_of_text;

  assign is_space  = c inside {[8'd9:8'd13], 8'd32};
  assign is_digit  = c inside {["0":"9"]};
  assign is_alpha  = c inside {["a":"z"], ["A":"Z"], "_"};
  assign is_punct  = (c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96],
                               [8'd123:8'd126]}) && (c != "_");
  assign pend_pair = punct_q inside {"=", "!", "<", ">"};
  assign digit     = c[3:0];

  // acc * 10 + digit, clamp when past the 63-bit ceiling
  assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign acc_sum  = acc_x10 + 67'(digit);
  assign acc_next = (acc_sum > 67'(VALUE_MAX)) ? VALUE_MAX : acc_sum[62:0];

  assign pos_inc = (&pos_q) ? pos_q : pos_q + 1'b1;
  assign len_inc = (&len_q) ? len_q : len_q + 1'b1;

  assign pos_ext   = 32'(pos_q);
  assign start_ext = 32'(start_q);
  assign len_ext   = 32'(len_q);

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      narrow_cont[k]  = (len_q < OFFSET_BITS'(KW_LEN[k])) &&
                        (kw_char(2'(k), len_q[2:0]) == c);
      narrow_first[k] = kw_char(2'(k), 3'd0) == c;
    end
  end

  always_comb begin
    is_kw = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cand_q[k] && (len_q == OFFSET_BITS'(KW_LEN[k]))) begin
        is_kw = 1'b1;
      end
    end
  end

  always_comb begin
    flush_w              = '0;
    flush_w.start_offset = start_ext[15:0];
    flush_w.length       = len_ext[15:0];
    flush_v              = 1'b1;
    case (mode_q)
      MODE_NUM: begin
        flush_w.kind         = KIND_NUM;
        flush_w.number_value = acc_q;
      end
      MODE_IDENT: begin
        flush_w.kind = is_kw ? KIND_KEYWORD : KIND_IDENT;
      end
      MODE_PUNCT: begin
        flush_w.kind       = KIND_PUNCT;
        flush_w.length     = 16'd1;
        flush_w.first_char = punct_q;
      end
      default: begin
        flush_v = 1'b0;
      end
    endcase

    pair_w              = '0;
    pair_w.kind         = KIND_PUNCT;
    pair_w.start_offset = start_ext[15:0];
    pair_w.length       = 16'd2;
    pair_w.first_char   = punct_q;
    pair_w.second_char  = c;

    end_w              = '0;
    end_w.kind         = KIND_END;
    end_w.start_offset = pos_ext[15:0];

    err_w              = '0;
    err_w.kind         = KIND_ERROR;
    err_w.start_offset = pos_ext[15:0];
    err_w.length       = 16'd1;
    err_w.first_char   = c;
  end

  // slot a: flushed or paired token, slot b: end or error token
  always_comb begin
    logic used;
    used    = 1'b0;
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    acc_d   = acc_q;
    punct_d = punct_q;
    cand_d  = cand_q;
    a_v     = 1'b0;
    a_w     = flush_w;
    b_v     = 1'b0;
    b_w     = end_w;

    if (eot) begin
      if (mode_q != MODE_ERROR) begin
        a_v = flush_v;
        b_v = 1'b1;
      end
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      start_d = '0;
      len_d   = '0;
      acc_d   = '0;
      punct_d = '0;
      cand_d  = '1;
    end else if (mode_q != MODE_ERROR) begin
      if (mode_q == MODE_NUM && is_digit) begin
        acc_d = acc_next;
        len_d = len_inc;
        used  = 1'b1;
      end else if (mode_q == MODE_IDENT && (is_alpha || is_digit)) begin
        cand_d = cand_q & narrow_cont;
        len_d  = len_inc;
        used   = 1'b1;
      end else if (mode_q == MODE_PUNCT && c == "=" && pend_pair) begin
        a_v    = 1'b1;
        a_w    = pair_w;
        mode_d = MODE_IDLE;
        used   = 1'b1;
      end else begin
        a_v    = flush_v;
        mode_d = MODE_IDLE;
      end

      if (!used && !is_space) begin
        start_d = pos_q;
        len_d   = OFFSET_BITS'(1);
        acc_d   = '0;
        punct_d = '0;
        cand_d  = '1;
        if (is_digit) begin
          mode_d = MODE_NUM;
          acc_d  = 63'(digit);
        end else if (is_alpha) begin
          mode_d = MODE_IDENT;
          cand_d = narrow_first;
        end else if (is_punct) begin
          mode_d  = MODE_PUNCT;
          punct_d = c;
        end else begin
          mode_d = MODE_ERROR;
          b_v    = 1'b1;
          b_w    = err_w;
        end
      end
      pos_d = pos_inc;
    end
  end

  // pack the results into the lowest slots and mark the final one
  always_comb begin
    n    = 2'(a_v) + 2'(b_v);
    res0 = a_v ? a_w : b_w;
    res1 = b_w;
    res0.last_of_run = (n == 2'd1);
    res1.last_of_run = 1'b1;
  end

  assign push_o.cnt = step_i ? n : 2'd0;
  assign push_o.w0  = res0;
  assign push_o.w1  = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      acc_q   <= '0;
      punct_q <= '0;
      cand_q  <= '1;
    end else if (step_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      punct_q <= punct_d;
      cand_q  <= cand_d;
    end
  end

endmodule

FILE: rtl/core/csl_fifo.sv
module csl_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csl_pkg::push_t     push_i,
  input  logic               pop_i,
  output logic               out_valid_o,
  output csl_pkg::out_word_t out_word_o,
  output logic               full_o
);
  import csl_pkg::*;

  out_word_t        mem_q [RES_DEPTH];
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d, tail_nxt;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop      = pop_i && (count_q != '0);
  assign tail_nxt    = tail_q + 1'b1;
  assign tail_d      = tail_q + PTR_W'(push_i.cnt);
  assign head_d      = do_pop ? head_q + 1'b1 : head_q;
  assign count_d     = count_q + CNT_W'(push_i.cnt) - CNT_W'(do_pop);

  assign out_valid_o = (count_q != '0);
  assign out_word_o  = mem_q[head_q];
  // hold off the producer unless room for two words remains
  assign full_o      = count_q > CNT_W'(RES_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[tail_q] <= push_i.w0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[tail_nxt] <= push_i.w1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/core/c_subset_lexer_top.sv
// Streaming lexer for a small C subset.
// Input channel: one word per source byte (ch), or an end_of_text word that
// flushes the pending token and closes the text with an end token, if no error.
// Output channel: token words with kind, offset, length, number value and
// punctuator bytes; last_of_run marks the final token caused by one input.
// An input word is taken at a clock edge with in_valid_i high and in_stall_o
// low; tokens leave the same way on out_valid_o / out_stall_i.
// The tokens an input causes are written into the result queue as that input
// is taken; a second token follows once the first has left.
// Throughput: one input byte per cycle while unstalled. The step logic and
// the lexer state update in the cycle of acceptance; tokens go to a four-word
// result queue. An input may cause two tokens, so the input stalls while
// fewer than two queue slots are free; with a stalled receiver the queue
// fills and the input stalls once three or four words are held.
// Reset clears the lexer state and empties the queue; the block accepts
// input in the first cycle after reset.
module c_subset_lexer_top #(
  parameter int unsigned OFFSET_BITS = csl_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  csl_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output csl_pkg::out_word_t out_word_o
);
  import csl_pkg::*;

  logic  full;
  logic  step;
  push_t push;

  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  csl_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .in_word_i(in_word_i),
    .push_o   (push)
  );

  csl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (!out_stall_i),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o),
    .full_o     (full)
  );

endmodule

FILE: rtl/core/csl_checker.sv
module csl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input csl_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input csl_pkg::out_word_t out_word_o
);
  import csl_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ in_stall_o ^ (^in_word_i);

  // held word must not move while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_END |->
      out_word_o.length == 16'd0 && out_word_o.last_of_run)
    else $error("malformed end token");

  a_punct_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_PUNCT |->
      (out_word_o.length == 16'd1 && out_word_o.second_char == 8'd0) ||
      (out_word_o.length == 16'd2 && out_word_o.second_char == "="))
    else $error("malformed punctuator token");

  a_value_num_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind != KIND_NUM |-> out_word_o.number_value == '0)
    else $error("number value on a non-number token");

endmodule

bind c_subset_lexer_top csl_checker u_csl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

FILE: bench/c_subset_lexer_top_tb.sv
module c_subset_lexer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned POS_MAX = (1 << OFFSET_BITS_DEF) - 1;
  localparam int unsigned KW_LIKE_N = 16;

  typedef enum logic [2:0] {
    M_IDLE,
    M_NUM,
    M_IDENT,
    M_PUNCT,
    M_ERROR
  } lex_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  c_subset_lexer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lexer state mirror
  lex_mode_e   mode_q;
  int unsigned pos_q;
  int unsigned tstart_q;
  int unsigned tlen_q;
  logic [62:0] acc_q;
  logic [7:0]  pend_q;
  logic [2:0]  kwc_q;

  string kw_word[3] = '{"return", "if", "else"};
  string kw_like[KW_LIKE_N] = '{"return", "if", "else", "i", "iff", "el", "els", "elses",
                                "r", "retur", "returns", "ifelse", "_if", "Else", "RETURN",
                                "if0"};
  string punct_set = "!\"#$%&'()*+,-./:;<=>?@[\\]^`{|}~";
  string cmp_heads = "=!<>";

  out_word_t   step_tokens[$];
  out_word_t   tokens_due[$];
  logic [7:0]  text_q[$];

  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  function automatic bit is_ws(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_punc(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic int unsigned sat_step(input int unsigned v);
    return (v < POS_MAX) ? v + 1 : POS_MAX;
  endfunction

  function automatic out_word_t make_token(input kind_e k, input int unsigned st,
                                           input int unsigned ln, input logic [62:0] v,
                                           input logic [7:0] c1, input logic [7:0] c2);
    out_word_t t;
    t.kind         = k;
    t.start_offset = st[15:0];
    t.length       = ln[15:0];
    t.number_value = v;
    t.first_char   = c1;
    t.second_char  = c2;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  task automatic lex_reset();
    mode_q   = M_IDLE;
    pos_q    = 0;
    tstart_q = 0;
    tlen_q   = 0;
    acc_q    = '0;
    pend_q   = '0;
    kwc_q    = 3'b111;
  endtask

  task automatic narrow_keywords(input logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (tlen_q >= kw_word[k].len() || kw_word[k][tlen_q] != c) kwc_q[k] = 1'b0;
    end
  endtask

  task automatic flush_token();
    kind_e k;
    case (mode_q)
      M_NUM: begin
        step_tokens.push_back(make_token(KIND_NUM, tstart_q, tlen_q, acc_q, 8'd0, 8'd0));
      end
      M_IDENT: begin
        k = KIND_IDENT;
        for (int i = 0; i < 3; i++) begin
          if (kwc_q[i] && tlen_q == kw_word[i].len()) k = KIND_KEYWORD;
        end
        step_tokens.push_back(make_token(k, tstart_q, tlen_q, '0, 8'd0, 8'd0));
      end
      M_PUNCT: begin
        step_tokens.push_back(make_token(KIND_PUNCT, tstart_q, 1, '0, pend_q, 8'd0));
      end
      default: begin
      end
    endcase
    mode_q = M_IDLE;
  endtask

  // work out the tokens one accepted word causes and queue them
  task automatic lex_byte(input in_word_t w);
    logic [7:0]  c;
    logic [63:0] digit;
    bit          used;
    c = w.ch;
    used = 1'b0;
    step_tokens.delete();
    if (w.end_of_text) begin
      if (mode_q != M_ERROR) begin
        flush_token();
        step_tokens.push_back(make_token(KIND_END, pos_q, 0, '0, 8'd0, 8'd0));
      end
      lex_reset();
    end else if (mode_q != M_ERROR) begin
      if (mode_q == M_NUM && is_dig(c)) begin
        digit = {56'd0, c} - 64'h30;
        if ({1'b0, acc_q} > ({1'b0, VALUE_MAX} - digit) / 64'd10) begin
          acc_q = VALUE_MAX;
        end else begin
          acc_q = 63'({1'b0, acc_q} * 64'd10 + digit);
        end
        tlen_q = sat_step(tlen_q);
        used = 1'b1;
      end else if (mode_q == M_IDENT && (is_word_start(c) || is_dig(c))) begin
        narrow_keywords(c);
        tlen_q = sat_step(tlen_q);
        used = 1'b1;
      end else if (mode_q == M_PUNCT && c == "=" &&
                   (pend_q == "=" || pend_q == "!" || pend_q == "<" || pend_q == ">")) begin
        step_tokens.push_back(make_token(KIND_PUNCT, tstart_q, 2, '0, pend_q, c));
        mode_q = M_IDLE;
        used = 1'b1;
      end else begin
        flush_token();
      end
      if (!used && !is_ws(c)) begin
        tstart_q = pos_q;
        tlen_q   = 1;
        acc_q    = '0;
        pend_q   = '0;
        kwc_q    = 3'b111;
        if (is_dig(c)) begin
          mode_q = M_NUM;
          acc_q  = 63'(c - 8'h30);
        end else if (is_word_start(c)) begin
          mode_q = M_IDENT;
          tlen_q = 0;
          narrow_keywords(c);
          tlen_q = 1;
        end else if (is_punc(c)) begin
          mode_q = M_PUNCT;
          pend_q = c;
        end else begin
          step_tokens.push_back(make_token(KIND_ERROR, pos_q, 1, '0, c, 8'd0));
          mode_q = M_ERROR;
        end
      end
      pos_q = sat_step(pos_q);
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endtask

  task automatic send_word(input logic [7:0] c, input logic eot);
    in_word_t w;
    w.ch = c;
    w.end_of_text = eot;
    while (tx_gaps && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lex_byte(w);
    words_sent++;
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // send the collected bytes, close with end of text, then empty the buffer
  task automatic send_text(input logic [7:0] eot_ch);
    foreach (text_q[i]) send_word(text_q[i], 1'b0);
    send_word(eot_ch, 1'b1);
    text_q.delete();
  endtask

  task automatic wait_drained();
    while (tokens_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_word_start();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_word_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_word_start();
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] rand_bad_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 8));
      1: return 8'($urandom_range(14, 31));
      2: return 8'h7F;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  task automatic add_random_token();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      add_str(kw_like[$urandom_range(0, KW_LIKE_N - 1)]);
    end else if (r < 35) begin
      n = $urandom_range(1, 8);
      text_q.push_back(rand_word_start());
      repeat (n - 1) text_q.push_back(rand_word_char());
    end else if (r < 55) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 4);
      repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
    end else if (r < 72) begin
      text_q.push_back(cmp_heads[$urandom_range(0, 3)]);
      if ($urandom_range(0, 1)) text_q.push_back("=");
    end else if (r < 96) begin
      text_q.push_back(punct_set[$urandom_range(0, punct_set.len() - 1)]);
    end else begin
      text_q.push_back(rand_bad_byte());
    end
    if ($urandom_range(0, 1)) text_q.push_back(rand_space());
  endtask

  task automatic build_random_text();
    if ($urandom_range(0, 9) == 0) begin
      // raw noise: any byte value at all
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) text_q.push_back(rand_space());
      repeat ($urandom_range(1, 10)) add_random_token();
    end
  endtask

  // receiver: random stall, or a long hold when requested
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_gaps && ($urandom_range(0, 99) < 8);
    end
  end

  function automatic void check_field(input string fname, input logic [62:0] want_v,
                                      input logic [62:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: token with none expected, expected nothing, got %p", $time,
                 out_word_o);
        mismatches++;
      end else begin
        want = tokens_due.pop_front();
        check_field("kind", 63'(want.kind), 63'(out_word_o.kind));
        check_field("start_offset", 63'(want.start_offset), 63'(out_word_o.start_offset));
        check_field("length", 63'(want.length), 63'(out_word_o.length));
        check_field("number_value", want.number_value, out_word_o.number_value);
        check_field("first_char", 63'(want.first_char), 63'(out_word_o.first_char));
        check_field("second_char", 63'(want.second_char), 63'(out_word_o.second_char));
        check_field("last_of_run", 63'(want.last_of_run), 63'(out_word_o.last_of_run));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("c_subset_lexer_top regression: fail");
      $finish;
    end
  end

  // keyword, pair, number, identifier, lone punctuator, error and error-mode cases
  task automatic test_directed();
    add_str("else!=0 Z_~");
    text_q.push_back(8'h09);
    send_text(8'hFF);
    add_str("(");
    text_q.push_back(8'hFF);
    add_str("a");
    send_text(8'h00);
    text_q.push_back(8'h00);
    send_text(8'h00);
    add_str(">==<");
    send_text(8'h5A);
  endtask

  task automatic test_random_texts(input int unsigned n_words);
    int unsigned stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      build_random_text();
      send_text(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_gapless_stream();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random_texts(150);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // hold the output long enough for the result queue to fill and stall the input
  task automatic test_output_hold();
    hold_req = 200;
    repeat (40) begin
      text_q.push_back(punct_set[$urandom_range(0, punct_set.len() - 1)]);
    end
    send_text(8'h00);
  endtask

  task automatic test_sender_pause();
    add_str("return x1 >= 42 ");
    foreach (text_q[i]) send_word(text_q[i], 1'b0);
    text_q.delete();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    add_str("if else==7");
    send_text(8'h80);
  endtask

  // number values run into their limit
  task automatic test_saturation();
    add_str("9223372036854775807 9223372036854775808 99999999999999999999999 ");
    add_str(" 7+");
    send_text(8'h01);
  endtask

  initial begin
    lex_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_texts(150);
    test_gapless_stream();
    test_output_hold();
    test_sender_pause();
    test_saturation();
    test_random_texts(150);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("c_subset_lexer_top regression: pass");
    end else begin
      $display("c_subset_lexer_top regression: fail");
    end
    $finish;
  end

endmodule
